// File: rtl/cdr_pkg.sv
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared types, constants and tables of the character reference decoder.
// ----------------------------------------------------------------------------
package cdr_pkg;

    localparam int MAX_NAME_LEN_DEF = 8;
    localparam int ENTITY_COUNT_DEF = 253;
    localparam int ROM_SIZE         = 253;
    localparam int ROM_IDX_W        = 9;
    localparam int KEY_BYTES        = 8;
    localparam int KEY_W            = 8 * KEY_BYTES;
    localparam int CP_W             = 21;
    localparam int QDEPTH           = 4;

    localparam logic [CP_W-1:0] CODE_MAX = 21'h10FFFF;
    localparam logic [7:0]      CH_AMP   = 8'h26;
    localparam logic [7:0]      CH_SEMI  = 8'h3B;
    localparam logic [7:0]      CH_HASH  = 8'h23;

    typedef enum logic [2:0] {
        M_TEXT, M_AMP, M_HASH, M_DEC, M_HEX, M_NAME, M_SKIP
    } t_mode;

    typedef enum logic [1:0] {K_RAW, K_CP, K_NAME, K_MARK} t_kind;

    typedef enum logic [1:0] {B_IDLE, B_SEARCH, B_EMIT} t_bstate;

    // one classified item handed from front to back
    typedef struct packed {
        t_kind             kind;
        logic [CP_W-1:0]   cp;     // code point, or the raw byte in the low bits
        logic [KEY_W-1:0]  key;    // name, first char in the highest used byte
        logic [3:0]        len;
        logic              last;
        logic              open;
    } t_cmd;

    localparam logic [KEY_W-1:0] ROM_NM [ROM_SIZE] = '{
        "AElig","Aacute","Acirc","Agrave","Alpha","Aring","Atilde","Auml","Beta",
        "Ccedil","Chi","Dagger","Delta","ETH","Eacute","Ecirc","Egrave","Epsilon",
        "Eta","Euml","Gamma","Iacute","Icirc","Igrave","Iota","Iuml","Kappa",
        "Lambda","Mu","Ntilde","Nu","OElig","Oacute","Ocirc","Ograve","Omega",
        "Omicron","Oslash","Otilde","Ouml","Phi","Pi","Prime","Psi","Rho",
        "Scaron","Sigma","THORN","Tau","Theta","Uacute","Ucirc","Ugrave",
        "Upsilon","Uuml","Xi","Yacute","Yuml","Zeta",
        "aacute","acirc","acute","aelig","agrave","alefsym","alpha","amp","and",
        "ang","apos","aring","asymp","atilde","auml","bdquo","beta","brvbar",
        "bull","cap","ccedil","cedil","cent","chi","circ","clubs","cong","copy",
        "crarr","cup","curren","dArr","dagger","darr","deg","delta","diams",
        "divide","eacute","ecirc","egrave","empty","emsp","ensp","epsilon",
        "equiv","eta","eth","euml","euro","exist","fnof","forall","frac12",
        "frac14","frac34","frasl","gamma","ge","gt","hArr","harr","hearts",
        "hellip","iacute","icirc","iexcl","igrave","image","infin","int","iota",
        "iquest","isin","iuml","kappa","lArr","lambda","lang","laquo","larr",
        "lceil","ldquo","le","lfloor","lowast","loz","lrm","lsaquo","lsquo","lt",
        "macr","mdash","micro","middot","minus","mu","nabla","nbsp","ndash","ne",
        "ni","not","notin","nsub","ntilde","nu","oacute","ocirc","oelig",
        "ograve","oline","omega","omicron","oplus","or","ordf","ordm","oslash",
        "otilde","otimes","ouml","para","part","permil","perp","phi","pi","piv",
        "plusmn","pound","prime","prod","prop","psi","quot","rArr","radic",
        "rang","raquo","rarr","rceil","rdquo","real","reg","rfloor","rho","rlm",
        "rsaquo","rsquo","sbquo","scaron","sdot","sect","shy","sigma","sigmaf",
        "sim","spades","sub","sube","sum","sup","sup1","sup2","sup3","supe",
        "szlig","tau","there4","theta","thetasym","thinsp","thorn","tilde",
        "times","trade","uArr","uacute","uarr","ucirc","ugrave","uml","upsih",
        "upsilon","uuml","weierp","xi","yacute","yen","yuml","zeta","zwj","zwnj"
    };

    localparam logic [CP_W-1:0] ROM_CP [ROM_SIZE] = '{
        198,193,194,192,913,197,195,196,914,
        199,935,8225,916,208,201,202,200,917,
        919,203,915,205,206,204,921,207,922,
        923,924,209,925,338,211,212,210,937,
        927,216,213,214,934,928,8243,936,929,
        352,931,222,932,920,218,219,217,
        933,220,926,221,376,918,
        225,226,180,230,224,8501,945,38,8743,
        8736,39,229,8776,227,228,8222,946,166,
        8226,8745,231,184,162,967,710,9827,8773,169,
        8629,8746,164,8659,8224,8595,176,948,9830,
        247,233,234,232,8709,8195,8194,949,
        8801,951,240,235,8364,8707,402,8704,189,
        188,190,8260,947,8805,62,8660,8596,9829,
        8230,237,238,161,236,8465,8734,8747,953,
        191,8712,239,954,8656,955,12296,171,8592,
        8968,8220,8804,8970,8727,9674,8206,8249,8216,60,
        175,8212,181,183,8722,956,8711,160,8211,8800,
        8715,172,8713,8836,241,957,243,244,339,
        242,8254,969,959,8853,8744,170,186,248,
        245,8855,246,182,8706,8240,8869,966,960,982,
        177,163,8242,8719,8733,968,34,8658,8730,
        12297,187,8594,8969,8221,8476,174,8971,961,8207,
        8250,8217,8218,353,8901,167,173,963,962,
        8764,9824,8834,8838,8721,8835,185,178,179,8839,
        223,964,8756,952,977,8201,254,732,
        215,8482,8657,250,8593,251,249,168,978,
        965,252,8472,958,253,165,255,950,8205,8204
    };

    function automatic logic [KEY_W-1:0] rom_name(input logic [ROM_IDX_W-1:0] i);
        rom_name = (i < ROM_IDX_W'(ROM_SIZE)) ? ROM_NM[i[7:0]] : '0;
    endfunction

    function automatic logic [CP_W-1:0] rom_code(input logic [ROM_IDX_W-1:0] i);
        rom_code = (i < ROM_IDX_W'(ROM_SIZE)) ? ROM_CP[i[7:0]] : '0;
    endfunction

    function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
        if (cp <= 21'h7F)        utf8_len = 3'd1;
        else if (cp <= 21'h7FF)  utf8_len = 3'd2;
        else if (cp <= 21'hFFFF) utf8_len = 3'd3;
        else                     utf8_len = 3'd4;
    endfunction

    // byte k of an n-byte sequence, lead byte first
    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [2:0] n,
                                             input logic [2:0] k);
        logic [7:0] b;
        b = 8'h00;
        case (n)
            3'd2: begin
                b = (k == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            3'd3: begin
                case (k)
                    3'd0:    b = {4'b1110, cp[15:12]};
                    3'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (k)
                    3'd0:    b = {5'b11110, cp[20:18]};
                    3'd1:    b = {2'b10, cp[17:12]};
                    3'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = cp[7:0];
        endcase
        utf8_byte = b;
    endfunction

endpackage

// File: rtl/cdr_front.sv
// ----------------------------------------------------------------------------
// cdr_front
// Parses one byte a cycle unless the queue is full; accumulates references, issues classified items.
// ----------------------------------------------------------------------------
module cdr_front import cdr_pkg::*; #(
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int LEN_W = $clog2(MAX_NAME_LEN + 1);

    t_mode             r_mode, n_mode;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CP_W-1:0]   r_code, n_code;
    logic              r_big, n_big;
    logic              r_long, n_long;
    logic [KEY_W-1:0]  r_key, n_key;

    logic              acc, produce, is_dec, is_hex, hexmode;
    logic [3:0]        dval;
    logic [CP_W+3:0]   sum;
    logic [3:0]        tz;
    logic              tz_run, lead_nz;
    logic [KEY_W-1:0]  key_s;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;

    always_comb begin
        is_dec = (i_byte >= "0") && (i_byte <= "9");
        is_hex = ((i_byte >= "a") && (i_byte <= "f")) || ((i_byte >= "A") && (i_byte <= "F"));
        if (is_dec)
            dval = i_byte[3:0];
        else
            dval = 4'(i_byte[3:0] + 4'd9);  // 'a'/'A' have low nibble 1
        hexmode = (r_mode == M_HEX);
        if (hexmode)
            sum = {r_code, 4'b0} + (CP_W+4)'(dval);
        else
            sum = {r_code, 3'b0} + {2'b0, r_code, 1'b0} + (CP_W+4)'(dval);
    end

    // trailing zero bytes of a name still match a table name, so strip them;
    // a zero lead char never matches
    always_comb begin
        tz      = 4'd0;
        tz_run  = 1'b1;
        lead_nz = 1'b0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (tz_run && r_key[b*8 +: 8] == 8'h00)
                tz = 4'(tz + 1'b1);
            else
                tz_run = 1'b0;
            if (LEN_W'(b + 1) == r_len && r_key[b*8 +: 8] != 8'h00)
                lead_nz = 1'b1;
        end
        key_s = r_key >> (8 * tz);
    end

    always_comb begin
        n_mode  = r_mode;
        n_len   = r_len;
        n_code  = r_code;
        n_big   = r_big;
        n_long  = r_long;
        n_key   = r_key;
        produce = 1'b0;
        o_cmd.kind = K_RAW;
        o_cmd.cp   = {{(CP_W-8){1'b0}}, i_byte};
        o_cmd.key  = r_key;
        o_cmd.len  = 4'(r_len);
        if (r_mode == M_TEXT) begin
            if (i_byte == CH_AMP) begin
                n_len  = '0;
                n_code = '0;
                n_big  = 1'b0;
                n_long = 1'b0;
                n_mode = M_AMP;
            end else begin
                produce = 1'b1;
            end
        end else if (i_byte == CH_SEMI) begin
            if ((r_mode == M_HASH || r_mode == M_DEC || r_mode == M_HEX) && !r_big) begin
                produce    = 1'b1;
                o_cmd.kind = K_CP;
                o_cmd.cp   = r_code;
            end else if (r_mode == M_NAME && !r_long && r_len <= LEN_W'(KEY_BYTES)
                         && lead_nz) begin
                produce    = 1'b1;
                o_cmd.kind = K_NAME;
                o_cmd.key  = key_s;
                o_cmd.len  = 4'(r_len) - tz;
            end
            n_mode = M_TEXT;
        end else begin
            case (r_mode)
                M_AMP: begin
                    if (i_byte == CH_HASH) begin
                        n_mode = M_HASH;
                    end else begin
                        n_key  = {{(KEY_W-8){1'b0}}, i_byte};
                        n_len  = LEN_W'(1);
                        n_mode = M_NAME;
                    end
                end
                M_HASH, M_DEC, M_HEX: begin
                    if (r_mode == M_HASH && (i_byte == "x" || i_byte == "X")) begin
                        n_mode = M_HEX;
                    end else if (is_dec || (hexmode && is_hex)) begin
                        if (!r_big) begin
                            if (sum > (CP_W+4)'(CODE_MAX))
                                n_big = 1'b1;
                            else
                                n_code = sum[CP_W-1:0];
                        end
                        if (r_mode == M_HASH)
                            n_mode = M_DEC;
                    end else begin
                        n_mode = M_SKIP;
                    end
                end
                M_NAME: begin
                    if (r_len < LEN_W'(MAX_NAME_LEN)) begin
                        n_key = {r_key[KEY_W-9:0], i_byte};
                        n_len = LEN_W'(r_len + 1'b1);
                    end else begin
                        n_long = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        o_cmd.last = i_last;
        o_cmd.open = (n_mode != M_TEXT);
        if (!produce)
            o_cmd.kind = K_MARK;
        if (i_last) begin
            n_mode = M_TEXT;
            n_len  = '0;
            n_code = '0;
            n_big  = 1'b0;
            n_long = 1'b0;
        end
        o_push = acc && (produce || i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_TEXT;
            r_len  <= '0;
            r_code <= '0;
            r_big  <= 1'b0;
            r_long <= 1'b0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_code <= n_code;
            r_big  <= n_big;
            r_long <= n_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc)
            r_key <= n_key;
    end

endmodule

// File: rtl/cdr_queue.sv
// ----------------------------------------------------------------------------
// cdr_queue
// Small register FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module cdr_queue import cdr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = $clog2(QDEPTH);

    t_cmd               r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [PTR_W:0]     r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PTR_W+1)'(QDEPTH));
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= PTR_W'(r_wp + 1'b1);
            if (i_pop)
                r_rp <= PTR_W'(r_rp + 1'b1);
            if (i_push && !i_pop)
                r_cnt <= (PTR_W+1)'(r_cnt + 1'b1);
            else if (i_pop && !i_push)
                r_cnt <= (PTR_W+1)'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_cmd;
    end

endmodule

// File: rtl/cdr_back.sv
// ----------------------------------------------------------------------------
// cdr_back
// Name search over the entity table and UTF-8 emission into the output register.
// ----------------------------------------------------------------------------
module cdr_back import cdr_pkg::*; #(
    parameter int ENTITY_COUNT = ENTITY_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_byte,
    output logic       o_bvalid,
    output logic       o_last,
    output logic       o_open
);

    localparam int LIMIT = (ENTITY_COUNT < ROM_SIZE) ? ENTITY_COUNT : ROM_SIZE;
    localparam int IDX_W = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;

    t_bstate            r_state, n_state;
    logic [IDX_W-1:0]   r_idx;
    t_cmd               r_cmd;
    t_kind              r_kind;
    logic [CP_W-1:0]    r_cp;
    logic [2:0]         r_n, r_k;
    logic               r_last, r_open;
    logic               r_ov;
    logic [7:0]         r_ob;
    logic               r_obv, r_olast, r_oend;

    logic               slot_free, emit, emit_done, take, match, search_end;
    logic               ld_en;
    t_kind              ld_kind;
    logic [CP_W-1:0]    ld_cp;
    logic               ld_last, ld_open;
    logic [KEY_W-1:0]   rom_nm;
    logic [ROM_IDX_W-1:0] ridx;

    assign slot_free = !r_ov || i_tready;
    assign ridx      = ROM_IDX_W'(r_idx);
    assign rom_nm    = rom_name(ridx);
    // lengths 1..8 only reach here; lead char nonzero rejects shorter table names
    assign match     = (rom_nm == r_cmd.key) && (rom_nm[(r_cmd.len - 4'd1) * 8 +: 8] != 8'h00);
    assign search_end = (r_idx == IDX_W'(LIMIT - 1));
    assign emit      = (r_state == B_EMIT) && slot_free;
    assign emit_done = emit && (r_k == r_n - 3'd1);
    assign take      = !i_empty && ((r_state == B_IDLE) || emit_done);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (take)
                    n_state = (i_head.kind == K_NAME) ? B_SEARCH : B_EMIT;
            end
            B_SEARCH: begin
                if (match || (search_end && r_cmd.last))
                    n_state = B_EMIT;
                else if (search_end)
                    n_state = B_IDLE;
            end
            B_EMIT: begin
                if (take)
                    n_state = (i_head.kind == K_NAME) ? B_SEARCH : B_EMIT;
                else if (emit_done)
                    n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // control and load selection
    always_comb begin
        o_pop   = take;
        ld_en   = 1'b0;
        ld_kind = i_head.kind;
        ld_cp   = i_head.cp;
        ld_last = i_head.last;
        ld_open = i_head.open;
        if (r_state == B_SEARCH) begin
            ld_last = r_cmd.last;
            ld_open = r_cmd.open;
            if (match) begin
                ld_en   = 1'b1;
                ld_kind = K_CP;
                ld_cp   = rom_code(ridx);
            end else if (search_end && r_cmd.last) begin
                ld_en   = 1'b1;
                ld_kind = K_MARK;
            end
        end else if (take && i_head.kind != K_NAME) begin
            ld_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit)
                r_ov <= 1'b1;
            else if (i_tready)
                r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_head.kind == K_NAME) begin
            r_cmd <= i_head;
            r_idx <= '0;
        end else if (r_state == B_SEARCH) begin
            r_idx <= IDX_W'(r_idx + 1'b1);
        end
        if (ld_en) begin
            r_kind <= ld_kind;
            r_cp   <= ld_cp;
            r_last <= ld_last;
            r_open <= ld_open;
            r_k    <= 3'd0;
            r_n    <= (ld_kind == K_CP) ? utf8_len(ld_cp) : 3'd1;
        end else if (emit) begin
            r_k <= 3'(r_k + 1'b1);
        end
        if (emit) begin
            case (r_kind)
                K_MARK:  r_ob <= 8'h00;
                K_RAW:   r_ob <= r_cp[7:0];
                default: r_ob <= utf8_byte(r_cp, r_n, r_k);
            endcase
            r_obv   <= (r_kind != K_MARK);
            r_olast <= r_last && (r_k == r_n - 3'd1);
            r_oend  <= r_last && r_open && (r_k == r_n - 3'd1);
        end
    end

    assign o_tvalid = r_ov;
    assign o_byte   = r_ob;
    assign o_bvalid = r_obv;
    assign o_last   = r_olast;
    assign o_open   = r_oend;

endmodule

// File: rtl/char_reference_decoder.sv
// ----------------------------------------------------------------------------
// char_reference_decoder
// Streaming decoder of HTML character references into UTF-8.
// ----------------------------------------------------------------------------
// Text bytes pass at one item per cycle unless the sink stalls or a name
// search is under way. A numeric reference gives 1 to 4 UTF-8 bytes, lead byte
// first. A named reference is matched by walking the entity table one entry per
// cycle, up to min(ENTITY_COUNT, 253) entries; a four-entry queue lets the
// parser keep taking input meanwhile. The last result of a text carries
// tlast; a bare end marker (tuser[0] = 0) appears when the last byte yields no
// output, and tuser[1] flags a text that ended inside a reference.
module char_reference_decoder import cdr_pkg::*; #(
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF,
    parameter int ENTITY_COUNT = ENTITY_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] out_valid, [1] ended_in_reference
    output logic       m_axis_tlast    // out_last
);

    logic push, pop, empty, full;
    t_cmd cmd, head;

    cdr_front #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    cdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    cdr_back #(.ENTITY_COUNT(ENTITY_COUNT)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_byte   (m_axis_tdata),
        .o_bvalid (m_axis_tuser[0]),
        .o_last   (m_axis_tlast),
        .o_open   (m_axis_tuser[1])
    );

    a_open_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("open-reference flag without tlast");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'h00))
        else $error("bare marker not final or not zero");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

// File: dv/char_reference_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_reference_decoder_test
// Streams text with numeric and named character references through the
// decoder under random source gaps and sink stalls. A behavioral decoder
// predicts the output bytes, end markers and the open-reference flag.
// ----------------------------------------------------------------------------
module char_reference_decoder_test;
    import cdr_pkg::*;

    localparam int NAME_MAX = 8;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       open;
    } t_out_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0; // in_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // [7:0] out_byte
    logic [1:0] m_axis_tuser;        // [0] out_valid, [1] ended_in_reference
    logic       m_axis_tlast;        // out_last

    char_reference_decoder u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    t_mode       pr_mode = M_TEXT;
    logic [7:0]  pr_name [NAME_MAX];
    int          pr_len = 0;
    logic [31:0] pr_code = 0;
    bit          pr_big = 0;
    bit          pr_long = 0;

    t_out_item   decoded_q[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_refs = 0;
    int          cycles = 0;
    bit          burst_on = 1'b1;
    int          burst_left = 0;

    t_out_item   step_out[$];

    function automatic void put_byte(logic [7:0] b, logic v);
        t_out_item r;
        r.data = b;
        r.valid = v;
        r.last = 1'b0;
        r.open = 1'b0;
        step_out = {step_out, r};
    endfunction

    function automatic void put_utf8(logic [31:0] cp);
        if (cp <= 32'h7F) begin
            put_byte(cp[7:0], 1'b1);
        end else if (cp <= 32'h7FF) begin
            put_byte({3'b110, cp[10:6]}, 1'b1);
            put_byte({2'b10, cp[5:0]}, 1'b1);
        end else if (cp <= 32'hFFFF) begin
            put_byte({4'b1110, cp[15:12]}, 1'b1);
            put_byte({2'b10, cp[11:6]}, 1'b1);
            put_byte({2'b10, cp[5:0]}, 1'b1);
        end else if (cp <= 32'h10FFFF) begin
            put_byte({5'b11110, cp[20:18]}, 1'b1);
            put_byte({2'b10, cp[17:12]}, 1'b1);
            put_byte({2'b10, cp[11:6]}, 1'b1);
            put_byte({2'b10, cp[5:0]}, 1'b1);
        end
    endfunction

    // table names are stored right-aligned; a name may carry zero bytes
    // after the table name and still match
    function automatic void find_name();
        logic [KEY_W-1:0] nm;
        int l;
        bit ok;
        if (pr_long || pr_len == 0 || pr_len > KEY_BYTES) return;
        for (int i = 0; i < ENTITY_COUNT_DEF && i < ROM_SIZE; i++) begin
            nm = ROM_NM[i];
            l = 0;
            for (int j = 0; j < KEY_BYTES; j++)
                if (nm[j*8 +: 8] != 8'h00) l = j + 1;
            ok = (pr_len >= l);
            for (int j = 0; j < pr_len; j++)
                if (pr_name[j] != ((j < l) ? nm[(l-1-j)*8 +: 8] : 8'h00)) ok = 1'b0;
            if (ok) begin
                put_utf8(32'(ROM_CP[i]));
                return;
            end
        end
    endfunction

    function automatic int digit_val(logic [7:0] c, bit hex);
        if (c >= "0" && c <= "9") return c - "0";
        if (!hex) return -1;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void acc_digit(int d, int base);
        logic [31:0] v;
        if (pr_big) return;
        v = pr_code * base + d;
        if (v > 32'h10FFFF) pr_big = 1;
        else pr_code = v;
    endfunction

    function automatic void clear_ref();
        pr_len = 0;
        pr_code = 0;
        pr_big = 0;
        pr_long = 0;
    endfunction

    function automatic void decode_byte(logic [7:0] c, logic last);
        int d;
        t_out_item r;
        step_out.delete();
        if (pr_mode == M_TEXT) begin
            if (c == CH_AMP) begin
                clear_ref();
                pr_mode = M_AMP;
            end else begin
                put_byte(c, 1'b1);
            end
        end else if (c == CH_SEMI) begin
            if ((pr_mode == M_HASH || pr_mode == M_DEC || pr_mode == M_HEX) && !pr_big)
                put_utf8(pr_code);
            else if (pr_mode == M_NAME)
                find_name();
            pr_mode = M_TEXT;
        end else if (pr_mode == M_AMP) begin
            if (c == CH_HASH) begin
                pr_mode = M_HASH;
            end else begin
                pr_name[0] = c;
                pr_len = 1;
                pr_mode = M_NAME;
            end
        end else if (pr_mode == M_HASH) begin
            d = digit_val(c, 1'b0);
            if (c == "x" || c == "X") begin
                pr_mode = M_HEX;
            end else if (d >= 0) begin
                acc_digit(d, 10);
                pr_mode = M_DEC;
            end else begin
                pr_mode = M_SKIP;
            end
        end else if (pr_mode == M_DEC || pr_mode == M_HEX) begin
            d = digit_val(c, pr_mode == M_HEX);
            if (d >= 0) acc_digit(d, pr_mode == M_HEX ? 16 : 10);
            else pr_mode = M_SKIP;
        end else if (pr_mode == M_NAME) begin
            if (pr_len < NAME_MAX) begin
                pr_name[pr_len] = c;
                pr_len++;
            end else begin
                pr_long = 1;
            end
        end
        if (last) begin
            if (step_out.size() == 0) put_byte(8'h00, 1'b0);
            r = step_out[$];
            r.last = 1'b1;
            r.open = (pr_mode != M_TEXT);
            step_out[step_out.size()-1] = r;
            pr_mode = M_TEXT;
            clear_ref();
        end
        foreach (step_out[i]) decoded_q = {decoded_q, step_out[i]};
    endfunction

    // send one item; bursts with random gaps in between
    task automatic send_byte(logic [7:0] c, logic last);
        if (burst_left <= 0) begin
            burst_on = !burst_on;
            burst_left = burst_on ? $urandom_range(1, 30) : $urandom_range(1, 6);
            if ($urandom_range(0, 5) == 0) burst_left = 0;
        end
        if (!burst_on && burst_left > 0) s_axis_tvalid <= 1'b0;
        while (!burst_on && burst_left > 0) begin
            @(posedge i_clk);
            burst_left--;
        end
        if (!burst_on) begin
            burst_on = 1'b1;
            burst_left = $urandom_range(1, 30);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(c, last);
        n_sent++;
        burst_left--;
    endtask

    task automatic send_text(string s, bit end_it);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_it && i == s.len() - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // sink stall pattern: periodic mask with random stalls, and periodic stretches of full speed
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[8]) m_axis_tready <= 1'b1;
        else m_axis_tready <= (stall_phase % 5 != 2) && ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        t_out_item e;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected output item data=%h", m_axis_tdata);
                errors++;
            end else begin
                e = decoded_q.pop_front();
                n_checked++;
                if (m_axis_tdata !== e.data) begin
                    $error("out_byte exp %h got %h", e.data, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] !== e.valid) begin
                    $error("out_valid exp %b got %b", e.valid, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("out_last exp %b got %b", e.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser[1] !== e.open) begin
                    $error("ended_in_reference exp %b got %b", e.open, m_axis_tuser[1]);
                    errors++;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_text("a&#0;&#x10FFFF;&#1114112;&#;&#x;&#X7f;", 0);
        send_text("&;&amp;&apos;&thetasym;&euro;&#xD800;&#-1;&# 5;&#xx1;", 0);
        send_text("&notaname;&toolongname;&AMP;&a&b;&#00000065;", 0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_text("&lt", 1);
        send_text("&", 1);
        send_text("x;", 1);
        drain();
    endtask

    // zero bytes inside names: trailing ones still match, others do not
    task automatic test_null_names();
        send_text("&lt", 0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_SEMI, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("gt;", 0);
        send_text("&l", 0);
        send_byte(8'h00, 1'b0);
        send_text("t;", 0);
        send_byte(CH_AMP, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_SEMI, 1'b1);
        drain();
    endtask

    function automatic string rand_ref();
        string s;
        string nm;
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0, 1, 2: begin
                nm = string'(ROM_NM[$urandom_range(0, ROM_SIZE-1)]);
                s = $sformatf("&%s;", nm);
            end
            3:       s = $sformatf("&#%0d;", $urandom_range(0, 32'h10FFFF));
            4:       s = $sformatf("&#x%0h;", $urandom_range(0, 32'h10FFFF));
            5:       s = $sformatf("&#X%0H;", $urandom_range(0, 32'h7FF));
            6:       s = $sformatf("&#%0d;", $urandom_range(0, 127));
            7:       s = $sformatf("&#x%0h;", $urandom_range(32'h110000, 32'h7FFFFFF));
            default: begin
                s = "&";
                repeat ($urandom_range(0, 10))
                    s = {s, string'(byte'($urandom_range(0, 255)))};
                if ($urandom_range(0, 1)) s = {s, ";"};
            end
        endcase
        return s;
    endfunction

    task automatic test_random();
        string s;
        while (n_sent < 340) begin
            s = "";
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 1)) s = {s, rand_ref()};
                else s = {s, string'(byte'($urandom_range(0, 255)))};
                n_refs++;
            end
            send_text(s, $urandom_range(0, 7) == 0);
            if (n_sent > 250 && n_sent < 300) drain(); // hold off until all output is in
        end
        send_text("&#x10FFFF;z", 1);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_null_names();
        test_random();
        drain();
        $display("Sent %0d bytes in %0d chunks, checked %0d output items.",
                 n_sent, n_refs, n_checked);
        if (errors == 0 && decoded_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
